[src/nrpal_pkg.sv]
// Shared types and constants for the nearest palette color matcher.
package nrpal_pkg;

  localparam int DEPTH_DEF = 64;     // default palette depth
  localparam int DEPTH_MAX_W = 9;    // holds any depth up to 256
  localparam int COLOR_W = 16;
  localparam int IDX_W = 6;
  localparam int LIMIT_W = 7;
  localparam int SQ_W = 2 * COLOR_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int ENTRY_W = 3 * COLOR_W;

  // Distance 10 at 655.35 raw steps per unit, squared and truncated.
  localparam logic [DIST_W-1:0] CLOSE_ENOUGH = DIST_W'(42948362);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index codes, taken from paddr[2].
  localparam logic REG_SCAN_LIMIT = 1'b0;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic wr;          // write one palette entry
    logic start;       // latch query color, clear best
    logic issue;       // read one entry into the distance pipe
    logic load_out;    // move result into the output register
    logic pass;        // result is a passthrough
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;        // distance pipe holds entries
    logic hit;         // close-enough entry found
    logic out_free;    // output register can take a result
  } dp_sts_t;

endpackage

[src/nrpal_if.sv]
// Valid/ready channels for query and load beats and for result beats.
interface nrpal_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [nrpal_pkg::IDX_W-1:0]   entry_index;
  logic [nrpal_pkg::COLOR_W-1:0] red;
  logic [nrpal_pkg::COLOR_W-1:0] green;
  logic [nrpal_pkg::COLOR_W-1:0] blue;
  logic                          is_transparent;

  modport source (output valid, kind, entry_index, red, green, blue, is_transparent,
                  input ready);
  modport sink (input valid, kind, entry_index, red, green, blue, is_transparent,
                output ready);
endinterface

interface nrpal_out_if;
  logic                        valid;
  logic                        ready;
  logic [nrpal_pkg::IDX_W-1:0] match_index;
  logic                        substituted;

  modport source (output valid, match_index, substituted, input ready);
  modport sink (input valid, match_index, substituted, output ready);
endinterface

[src/nrpal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nrpal_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/nrpal_ctrl.sv]
// Controller: accepts beats, sequences the palette scan, hands off results.
module nrpal_ctrl #(
  parameter int DEPTH = nrpal_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [nrpal_pkg::IDX_W-1:0]   in_entry_index,
  input  logic                          in_is_transparent,
  input  logic [nrpal_pkg::LIMIT_W-1:0] scan_limit,
  input  nrpal_pkg::dp_sts_t            sts,
  output nrpal_pkg::ctl_cmd_t           cmd,
  output logic [AW-1:0]                 wr_addr,
  output logic [AW-1:0]                 rd_addr
);
  import nrpal_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;

  logic [1:0]             state_r, state_nxt;
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [LW-1:0]          lim_r, lim_nxt;
  logic                   pass_r, pass_nxt;
  logic [DEPTH_MAX_W-1:0] slot_ext;
  logic                   slot_ok;
  logic [CW-1:0]          lim_ext;
  logic [CW-1:0]          depth_ext;
  logic [CW-1:0]          lim_sat;
  logic                   accept;
  logic                   scan_end;

  assign slot_ext  = {{(DEPTH_MAX_W - IDX_W){1'b0}}, in_entry_index};
  assign slot_ok   = (slot_ext < DEPTH_MAX_W'(DEPTH));
  assign wr_addr   = slot_ext[AW-1:0];
  assign rd_addr   = cnt_r[AW-1:0];

  assign lim_ext   = {{(CW - LIMIT_W){1'b0}}, scan_limit};
  assign depth_ext = CW'(DEPTH);
  assign lim_sat   = (lim_ext > depth_ext) ? depth_ext : lim_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign scan_end  = (sts.hit || (cnt_r == lim_r)) && !sts.busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.wr = slot_ok;
          end else begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            lim_nxt   = lim_sat[LW-1:0];
            if (in_is_transparent || (scan_limit == '0)) begin
              pass_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              pass_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = !sts.hit && (cnt_r < lim_r);
        if (cmd.issue) begin
          cnt_nxt = cnt_r + LW'(1);
        end
        if (scan_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.pass     = pass_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lim_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lim_r   <= lim_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

[src/nrpal_dp.sv]
// Datapath: palette RAM, pipelined distance unit, best tracker, output register.
module nrpal_dp #(
  parameter int DEPTH = nrpal_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nrpal_pkg::ctl_cmd_t           cmd,
  output nrpal_pkg::dp_sts_t            sts,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [nrpal_pkg::COLOR_W-1:0] in_red,
  input  logic [nrpal_pkg::COLOR_W-1:0] in_green,
  input  logic [nrpal_pkg::COLOR_W-1:0] in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nrpal_pkg::IDX_W-1:0]   out_match_index,
  output logic                          out_substituted
);
  import nrpal_pkg::*;

  logic [ENTRY_W-1:0] rdata;
  logic [COLOR_W-1:0] pr, pg, pb;

  logic [COLOR_W-1:0] qr_r, qg_r, qb_r;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]      idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COLOR_W-1:0] dr_r, dg_r, db_r;
  logic [SQ_W-1:0]    sr_r, sg_r, sb_r;
  logic [DIST_W-1:0]  sum_r;

  logic [DIST_W-1:0]  best_r;
  logic [AW-1:0]      best_idx_r;
  logic               have_best_r;
  logic               hit_r;
  logic               better;

  logic                   out_valid_r;
  logic [IDX_W-1:0]       match_r;
  logic                   subst_r;
  logic [DEPTH_MAX_W-1:0] best_ext;

  nrpal_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata ({in_red, in_green, in_blue}),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign pr = rdata[3*COLOR_W-1:2*COLOR_W];
  assign pg = rdata[2*COLOR_W-1:COLOR_W];
  assign pb = rdata[COLOR_W-1:0];

  // Hold the query color for the whole scan.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qr_r <= in_red;
      qg_r <= in_green;
      qb_r <= in_blue;
    end
  end

  // Stage valids and index tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_addr;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    // absolute channel differences
    dr_r <= (pr >= qr_r) ? (pr - qr_r) : (qr_r - pr);
    dg_r <= (pg >= qg_r) ? (pg - qg_r) : (qg_r - pg);
    db_r <= (pb >= qb_r) ? (pb - qb_r) : (qb_r - pb);
    // squares
    sr_r <= dr_r * dr_r;
    sg_r <= dg_r * dg_r;
    sb_r <= db_r * db_r;
    // distance
    sum_r <= DIST_W'(sr_r) + DIST_W'(sg_r) + DIST_W'(sb_r);
  end

  assign better = !have_best_r || (sum_r < best_r);

  // Keep the first strictly smaller distance; freeze after a close hit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.start) begin
      have_best_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (v4_r && !hit_r && better) begin
      have_best_r <= 1'b1;
      hit_r       <= (sum_r <= CLOSE_ENOUGH);
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && !hit_r && better) begin
      best_r     <= sum_r;
      best_idx_r <= idx4_r;
    end
  end

  assign best_ext = {{(DEPTH_MAX_W - AW){1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      match_r <= cmd.pass ? '0 : best_ext[IDX_W-1:0];
      subst_r <= !cmd.pass;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = match_r;
  assign out_substituted = subst_r;

  assign sts.busy     = v1_r || v2_r || v3_r || v4_r;
  assign sts.hit      = hit_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

[src/nearest_palette_color.sv]
// Top level of the nearest palette color matcher.
//
// Usage:
//   in_chan carries load and query beats. A load beat (kind 0) writes
//   red/green/blue into palette slot entry_index and returns nothing; a slot
//   at or beyond the palette depth is dropped. A query beat (kind 1) returns
//   one beat on out_chan with the index of the nearest palette entry (sum of
//   squared channel differences) over the first min(scan limit, depth)
//   entries, stopping at the first entry within the close-enough distance.
//   Transparent queries and scan limit 0 return substituted = 0, index 0.
//   The user writes the scan limit register over the APB port at address 0 only
//   while idle; the block itself does not enforce this. A load leaves the input
//   ready for the next beat. A query reads the entries of its scan, one per
//   cycle, into a four-stage distance pipe that drains before the result forms
//   (a close hit still reads up to four entries past it); the result then moves
//   into the output register and the input is freed as its beat appears. A
//   passthrough query skips the scan and waits only for a free output register.
// Reset clears control state and the scan limit; palette contents stay as they
// are and must be written before use. If the receiver stalls, the result holds
// in the output register; one more query scans, then the input stalls.
module nearest_palette_color #(
  parameter int PALETTE_DEPTH = nrpal_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nrpal_in_if.sink                     in_chan,
  nrpal_out_if.source                  out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nrpal_pkg::APB_AW-1:0] paddr,
  input  logic [nrpal_pkg::APB_DW-1:0] pwdata,
  output logic [nrpal_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);
  import nrpal_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [LIMIT_W-1:0] scan_limit_r;
  logic               reg_sel;
  ctl_cmd_t           cmd;
  dp_sts_t            sts;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  // APB register file: one register, written in the access phase.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SCAN_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      scan_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(APB_DW - LIMIT_W){1'b0}}, scan_limit_r} : '0;

  // Sequence accepts, scans and result hand-off.
  nrpal_ctrl #(
    .DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_kind           (in_chan.kind),
    .in_entry_index    (in_chan.entry_index),
    .in_is_transparent (in_chan.is_transparent),
    .scan_limit        (scan_limit_r),
    .sts               (sts),
    .cmd               (cmd),
    .wr_addr           (wr_addr),
    .rd_addr           (rd_addr)
  );

  // Palette storage, distance pipe and output register.
  nrpal_dp #(
    .DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .in_red          (in_chan.red),
    .in_green        (in_chan.green),
    .in_blue         (in_chan.blue),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_match_index (out_chan.match_index),
    .out_substituted (out_chan.substituted)
  );

endmodule

[tb/tb_nearest_palette_color.sv]
`timescale 1ns / 100ps
// Self-checking testbench for nearest_palette_color: palette loads and queries, scan predictor.
module tb_nearest_palette_color;
  import nrpal_pkg::*;

  localparam int PAL_DEPTH = 64;
  // Distance 10 on the 655.35-steps-per-unit scale, squared and truncated.
  localparam longint unsigned CLOSE_DIST = 64'd42948362;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES = 8;
  localparam int SETTLE_CYCLES = 80;     // a full 64-entry scan plus pipe drain
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [APB_AW-1:0] ADDR_SCAN_LIMIT = APB_AW'({REG_SCAN_LIMIT, 2'b00});

  typedef logic [COLOR_W-1:0] chan_t;
  typedef struct packed {
    logic [IDX_W-1:0] match_index;
    logic             substituted;
  } pick_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nrpal_in_if  in_if ();
  nrpal_out_if out_if ();

  nearest_palette_color #(.PALETTE_DEPTH(PAL_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Mirror of the block's state, updated as beats and register writes land.
  chan_t            pal_red   [PAL_DEPTH];
  chan_t            pal_green [PAL_DEPTH];
  chan_t            pal_blue  [PAL_DEPTH];
  logic [LIMIT_W-1:0] scan_limit_q = '0;

  pick_t pending_picks[$];   // expected result beats, oldest first
  int    fail_count = 0;
  int    gap_pct = 0;        // chance in percent of an idle burst, both sides
  bit    hold_req = 1'b0;    // ask the result side for one long hold-off

  // Entries actually searched: the limit saturates at the palette depth.
  function automatic int search_span();
    return (scan_limit_q > PAL_DEPTH) ? PAL_DEPTH : int'(scan_limit_q);
  endfunction

  // Scan the searched entries in index order: stop at the first new best that
  // is close enough, else keep the first entry with the smallest sum.
  function automatic pick_t nearest_pick(chan_t r, chan_t g, chan_t b, logic see_through);
    pick_t             pick;
    int                span;
    longint            dr, dg, db;
    longint unsigned   sum_sq, best;
    pick = '0;
    span = search_span();
    if (see_through || span == 0) return pick;
    pick.substituted = 1'b1;
    best = '1;
    for (int i = 0; i < span; i++) begin
      dr = longint'(r) - longint'(pal_red[i]);
      dg = longint'(g) - longint'(pal_green[i]);
      db = longint'(b) - longint'(pal_blue[i]);
      sum_sq = dr * dr + dg * dg + db * db;
      if (i == 0 || sum_sq < best) begin
        best = sum_sq;
        pick.match_index = IDX_W'(i);
        if (sum_sq <= CLOSE_DIST) break;
      end
    end
    return pick;
  endfunction

  // Move a channel by up to +/- reach steps, clamped to the channel range.
  function automatic chan_t nudge(chan_t c, int reach);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return chan_t'(v);
  endfunction

  // Offer one beat from a falling edge, hold it until accepted, then drop
  // valid at the next falling edge. Every call starts and ends on a falling edge.
  task automatic send_beat(logic kind, logic [IDX_W-1:0] slot, chan_t r, chan_t g, chan_t b,
                           logic see_through);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
      repeat ($urandom_range(1, 13)) @(negedge clk);
    in_if.kind = kind;
    in_if.entry_index = slot;
    in_if.red = r;
    in_if.green = g;
    in_if.blue = b;
    in_if.is_transparent = see_through;
    in_if.valid = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    // Every 6-bit slot lies inside the 64-deep palette, so a load always lands.
    if (kind == KIND_LOAD) begin
      pal_red[slot] = r;
      pal_green[slot] = g;
      pal_blue[slot] = b;
    end else begin
      pending_picks.push_back(nearest_pick(r, g, b, see_through));
    end
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic load_entry(logic [IDX_W-1:0] slot, chan_t r, chan_t g, chan_t b);
    send_beat(KIND_LOAD, slot, r, g, b, 1'($urandom));
  endtask

  task automatic query_color(chan_t r, chan_t g, chan_t b, logic see_through);
    send_beat(KIND_QUERY, IDX_W'($urandom), r, g, b, see_through);
  endtask

  // Wait for every expected beat, then for one more full scan, since a load
  // leaves no beat behind to show that the block is done.
  task automatic settle();
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic set_limit(logic [LIMIT_W-1:0] value);
    settle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_SCAN_LIMIT;
    pwdata = APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    scan_limit_q = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // One random beat. Many queries land near a searched entry so the early stop
  // and the tie rule get hit; loads often copy an entry to create ties.
  task automatic random_beat();
    int    span, sel, near_slot, reach;
    chan_t r, g, b;
    span = search_span();
    if (span == 0) span = PAL_DEPTH;
    near_slot = $urandom_range(0, span - 1);
    sel = $urandom_range(0, 99);
    reach = $urandom_range(0, 1) ? 4500 : 800;
    if (sel < 15) begin
      if ($urandom_range(0, 1))
        load_entry(IDX_W'($urandom), pal_red[near_slot], pal_green[near_slot],
                   pal_blue[near_slot]);
      else
        load_entry(IDX_W'($urandom), chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    end else if (sel < 25) begin
      query_color(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 1'b1);
    end else if (sel < 65) begin
      query_color(nudge(pal_red[near_slot], reach), nudge(pal_green[near_slot], reach),
                  nudge(pal_blue[near_slot], reach), 1'b0);
    end else if (sel < 85) begin
      query_color(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 1'b0);
    end else begin
      r = $urandom_range(0, 2) == 0 ? chan_t'($urandom) : {COLOR_W{1'($urandom)}};
      g = $urandom_range(0, 2) == 0 ? chan_t'($urandom) : {COLOR_W{1'($urandom)}};
      b = $urandom_range(0, 2) == 0 ? chan_t'($urandom) : {COLOR_W{1'($urandom)}};
      query_color(r, g, b, 1'b0);
    end
  endtask

  // Limit is 0 out of reset: every query passes through, palette untouched.
  task automatic test_passthrough();
    query_color('0, '0, '0, 1'b0);
    query_color('1, '1, '1, 1'b1);
    query_color(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 1'b0);
  endtask

  // Entry 1 is nearer than entry 0 for the first two queries, but only the first one
  // sits inside the close-enough distance of entry 0 and stops there.
  task automatic test_threshold_edges();
    load_entry(6'd0, '0, '0, '0);
    load_entry(6'd1, 16'd13000, '0, '0);
    load_entry(6'd2, '1, '1, '1);
    load_entry(6'd63, '1, '1, '1);
    set_limit(7'd3);
    query_color(16'd6553, '0, '0, 1'b0);
    query_color(16'd6554, '0, '0, 1'b0);
    query_color(16'd3783, 16'd3783, 16'd3783, 1'b0);
    query_color('1, '1, '1, 1'b0);
    query_color('1, '1, '1, 1'b1);
  endtask

  // Two equal entries far from the query: the lower index wins. Then limit 1.
  task automatic test_ties_and_limits();
    load_entry(6'd3, 16'd40000, 16'd20000, 16'd50000);
    load_entry(6'd4, 16'd40000, 16'd20000, 16'd50000);
    set_limit(7'd5);
    query_color(16'd40000, 16'd20000, 16'd60000, 1'b0);
    query_color(16'd40000, 16'd20000, 16'd50000, 1'b0);
    set_limit(7'd1);
    query_color('1, '1, '1, 1'b0);
    query_color(16'd6554, '0, '0, 1'b0);
  endtask

  // Write the whole palette so that any limit reads only written entries.
  task automatic test_palette_fill();
    gap_pct = 25;
    for (int i = 0; i < PAL_DEPTH; i++)
      load_entry(IDX_W'(i), chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    set_limit(7'd64);
    repeat (8) random_beat();
  endtask

  // Hold the result side off while queries keep coming, so the output
  // register fills and the input stalls behind it.
  task automatic test_backpressure();
    gap_pct = 0;
    hold_req = 1'b1;
    repeat (12) random_beat();
  endtask

  // Random beats across several limits, extremes included; no idling in the
  // last phase.
  task automatic test_random_settings();
    logic [LIMIT_W-1:0] limits [PHASES];
    int                 gaps   [PHASES];
    limits = '{7'd64, 7'd127, 7'd0, 7'd1, LIMIT_W'($urandom_range(2, 63)),
               LIMIT_W'($urandom_range(2, 63)), LIMIT_W'($urandom_range(65, 126)), 7'd64};
    gaps = '{20, 35, 10, 0, 50, 25, 15, 0};
    for (int p = 0; p < PHASES; p++) begin
      set_limit(limits[p]);
      gap_pct = gaps[p];
      repeat (RANDOM_ITEMS / PHASES) random_beat();
    end
  endtask

  // Result side ready: random idle bursts, or one long hold-off.
  initial begin : drive_result_ready
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold != 0) begin
        hold--;
        out_if.ready = 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_if.ready = 1'b0;
      end else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        stall = $urandom_range(0, 12);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    pick_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected result beat: match_index %0d substituted %0d",
               out_if.match_index, out_if.substituted);
        fail_count++;
      end else begin
        want = pending_picks.pop_front();
        if (out_if.match_index !== want.match_index) begin
          $error("match_index: expected %0d, got %0d", want.match_index, out_if.match_index);
          fail_count++;
        end
        if (out_if.substituted !== want.substituted) begin
          $error("substituted: expected %0d, got %0d", want.substituted, out_if.substituted);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nearest_palette_color regression: fail");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.entry_index = '0;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    in_if.is_transparent = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_passthrough();
    test_threshold_edges();
    test_ties_and_limits();
    test_palette_fill();
    test_backpressure();
    test_random_settings();
    settle();

    if (pending_picks.size() != 0) begin
      $error("%0d result beats never arrived", pending_picks.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("nearest_palette_color regression: pass");
    else
      $display("nearest_palette_color regression: fail");
    $finish;
  end

endmodule
